/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rc6_pkg.sv */
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared constants, payload types and controller command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rc6_pkg;

  localparam int unsigned ROUNDS      = 20;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned TABLE_SIZE  = 2 * ROUNDS + 4;
  localparam int unsigned MIX_STEPS   = 3 * TABLE_SIZE;
  localparam int unsigned KEY_ADDR_W  = $clog2(TABLE_SIZE);
  localparam int unsigned PAIR_W      = $clog2(ROUNDS + 2);
  localparam int unsigned SCHED_CNT_W = $clog2(MIX_STEPS);
  localparam int unsigned KW_IDX_W    = $clog2(KEY_WORDS);

  localparam logic [31:0] SCHED_P = 32'hb7e15163;
  localparam logic [31:0] SCHED_Q = 32'h9e3779b9;

  // Register file: index taken from the 8-byte slot bit of paddr
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;
  localparam logic REG_KEY  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef logic [KEY_WORDS-1:0][7:0] key_bytes_t;

  typedef struct packed {
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } in_block_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } out_block_t;

  typedef enum logic [1:0] {
    STEP_PRE,
    STEP_ROUND,
    STEP_POST
  } step_kind_e;

  typedef struct packed {
    // key schedule
    logic                  sched_en;
    logic                  sched_first;
    logic                  use_init;
    logic                  use_key;
    logic [KW_IDX_W-1:0]   kw_idx;
    logic [KEY_ADDR_W-1:0] wr_addr;
    logic [KEY_ADDR_W-1:0] sched_rd_addr;
    // block processing
    logic                  load;
    logic                  run_en;
    logic                  decrypt;
    step_kind_e            step;
    logic [PAIR_W-1:0]     rd_pair;
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/rc6_ctrl.sv */
// ----------------------------------------------------------------------------
// rc6_ctrl
// Sequencer for key expansion and the per-block round steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic            key_wr_i,
  input  wire logic            cfg_mode_i,
  output rc6_pkg::dp_cmd_t     cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  typedef enum logic [1:0] {
    S_SCHED,
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  localparam logic [rc6_pkg::PAIR_W-1:0] PAIR_LAST = rc6_pkg::PAIR_W'(rc6_pkg::ROUNDS + 1);
  localparam logic [rc6_pkg::SCHED_CNT_W-1:0] K_LAST =
    rc6_pkg::SCHED_CNT_W'(rc6_pkg::MIX_STEPS - 1);
  localparam logic [rc6_pkg::KEY_ADDR_W-1:0] I_LAST =
    rc6_pkg::KEY_ADDR_W'(rc6_pkg::TABLE_SIZE - 1);

  state_e                         state_q;
  logic [rc6_pkg::SCHED_CNT_W-1:0] k_q;
  logic [rc6_pkg::KEY_ADDR_W-1:0]  i_q;
  logic [rc6_pkg::PAIR_W-1:0]      step_q;
  logic                           mode_q;

  logic                           accept;
  logic [rc6_pkg::KEY_ADDR_W-1:0]  i_next;
  logic [rc6_pkg::PAIR_W-1:0]      step_next;
  logic [rc6_pkg::PAIR_W-1:0]      idle_pair;

  assign busy_o    = (state_q == S_SCHED) || (state_q == S_RUN);
  assign done_o    = (state_q == S_DONE);
  assign accept    = start_i && !busy_o && !key_wr_i;
  assign i_next    = (i_q == I_LAST) ? '0 : i_q + rc6_pkg::KEY_ADDR_W'(1);
  assign step_next = step_q + rc6_pkg::PAIR_W'(1);
  assign idle_pair = cfg_mode_i ? PAIR_LAST : '0;

  always_comb begin
    cmd_o               = '0;
    cmd_o.step          = rc6_pkg::STEP_ROUND;
    cmd_o.kw_idx        = k_q[rc6_pkg::KW_IDX_W-1:0];
    cmd_o.wr_addr       = i_q;
    cmd_o.sched_rd_addr = i_next;
    cmd_o.sched_first   = (k_q == '0);
    cmd_o.use_init      = (k_q < rc6_pkg::SCHED_CNT_W'(rc6_pkg::TABLE_SIZE));
    cmd_o.use_key       = (k_q < rc6_pkg::SCHED_CNT_W'(rc6_pkg::KEY_WORDS));
    cmd_o.decrypt       = mode_q;
    cmd_o.rd_pair       = idle_pair;
    unique case (state_q)
      S_SCHED: begin
        cmd_o.sched_en = 1'b1;
      end
      S_IDLE, S_DONE: begin
        cmd_o.load = accept;
      end
      S_RUN: begin
        cmd_o.run_en = 1'b1;
        if (step_q == '0) begin
          cmd_o.step = rc6_pkg::STEP_PRE;
        end else if (step_q == PAIR_LAST) begin
          cmd_o.step = rc6_pkg::STEP_POST;
        end
        // Prefetch the key pair of the following step
        if (step_q == PAIR_LAST) begin
          cmd_o.rd_pair = idle_pair;
        end else begin
          cmd_o.rd_pair = mode_q ? PAIR_LAST - step_next : step_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SCHED;
      k_q     <= '0;
      i_q     <= '0;
      step_q  <= '0;
      mode_q  <= 1'b0;
    end else if (key_wr_i) begin
      state_q <= S_SCHED;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      unique case (state_q)
        S_SCHED: begin
          if (k_q == K_LAST) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + rc6_pkg::SCHED_CNT_W'(1);
            i_q <= i_next;
          end
        end
        S_IDLE, S_DONE: begin
          if (accept) begin
            state_q <= S_RUN;
            step_q  <= '0;
            mode_q  <= cfg_mode_i;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RUN: begin
          if (step_q == PAIR_LAST) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_next;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rc6_datapath.sv */
// ----------------------------------------------------------------------------
// rc6_datapath
// Round key memory, key schedule step and one RC6 round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_datapath (
  input  wire logic                clk_i,
  input  wire rc6_pkg::dp_cmd_t    cmd_i,
  input  wire rc6_pkg::key_bytes_t key_i,
  input  wire rc6_pkg::in_block_t  in_block_i,
  output rc6_pkg::out_block_t      out_block_o
);

  localparam logic [4:0] SCHED_ROT = 5'd3;
  localparam logic [4:0] MIX_ROT   = 5'd5;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  function automatic logic [31:0] quad_mix(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl(p, MIX_ROT);
  endfunction

  // Round key store
  logic [31:0] key_mem [rc6_pkg::TABLE_SIZE];
  logic [31:0] rd_a_q, rd_b_q;
  logic [rc6_pkg::KEY_ADDR_W-1:0] addr_a, addr_b;

  // Schedule state
  logic [31:0] kw_q [rc6_pkg::KEY_WORDS];
  logic [31:0] sa_q, sb_q, init_q;
  logic [31:0] s_init, s_in, a_prev, b_prev, a_new, kw_cur, ab_sum, b_new;

  // Block state
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] t_val, u_val, k0, k1;

  assign addr_a = cmd_i.sched_en ? cmd_i.sched_rd_addr : {cmd_i.rd_pair, 1'b0};
  assign addr_b = {cmd_i.rd_pair, 1'b1};
  assign k0     = rd_a_q;
  assign k1     = rd_b_q;

  always_comb begin
    s_init = cmd_i.sched_first ? rc6_pkg::SCHED_P : init_q;
    s_in   = cmd_i.use_init ? s_init : rd_a_q;
    a_prev = cmd_i.sched_first ? '0 : sa_q;
    b_prev = cmd_i.sched_first ? '0 : sb_q;
    a_new  = rotl(s_in + a_prev + b_prev, SCHED_ROT);
    kw_cur = cmd_i.use_key ? {24'b0, key_i[cmd_i.kw_idx]} : kw_q[cmd_i.kw_idx];
    ab_sum = a_new + b_prev;
    b_new  = rotl(kw_cur + ab_sum, ab_sum[4:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_en) begin
      key_mem[cmd_i.wr_addr] <= a_new;
    end
    rd_a_q <= key_mem[addr_a];
    rd_b_q <= key_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_en) begin
      kw_q[cmd_i.kw_idx] <= b_new;
      sa_q               <= a_new;
      sb_q               <= b_new;
      init_q             <= s_init + rc6_pkg::SCHED_Q;
    end
  end

  // Both mixes run in parallel; the operands swap roles for decryption
  assign t_val = quad_mix(cmd_i.decrypt ? a_q : b_q);
  assign u_val = quad_mix(cmd_i.decrypt ? c_q : d_q);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    if (cmd_i.load) begin
      a_d = in_block_i.in_word0;
      b_d = in_block_i.in_word1;
      c_d = in_block_i.in_word2;
      d_d = in_block_i.in_word3;
    end else if (cmd_i.run_en) begin
      case (cmd_i.step)
        rc6_pkg::STEP_PRE: begin
          if (cmd_i.decrypt) begin
            a_d = a_q - k0;
            c_d = c_q - k1;
          end else begin
            b_d = b_q + k0;
            d_d = d_q + k1;
          end
        end
        rc6_pkg::STEP_ROUND: begin
          if (cmd_i.decrypt) begin
            a_d = rotr(d_q - k0, u_val[4:0]) ^ t_val;
            b_d = a_q;
            c_d = rotr(b_q - k1, t_val[4:0]) ^ u_val;
            d_d = c_q;
          end else begin
            a_d = b_q;
            b_d = rotl(c_q ^ u_val, t_val[4:0]) + k1;
            c_d = d_q;
            d_d = rotl(a_q ^ t_val, u_val[4:0]) + k0;
          end
        end
        rc6_pkg::STEP_POST: begin
          if (cmd_i.decrypt) begin
            b_d = b_q - k0;
            d_d = d_q - k1;
          end else begin
            a_d = a_q + k0;
            c_d = c_q + k1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  assign out_block_o = '{out_word0: a_q, out_word1: b_q, out_word2: c_q, out_word3: d_q};

endmodule

`default_nettype wire

/* rtl/rc6_block_cipher_byte_key.sv */
// ----------------------------------------------------------------------------
// rc6_block_cipher_byte_key
// RC6-32 block cipher with an 8-byte, byte-per-word key schedule.
// ----------------------------------------------------------------------------
// Raise start with a 128-bit block on in_block_i while busy is low; the block
// is taken at that edge. The result appears on out_block_o, marked by done_o for
// exactly one cycle, once the block has passed through one pre-whiten step,
// one round per cycle through the shared round datapath, and one post-whiten
// step, each fed by a key pair prefetched from the round key memory. The
// receiver cannot hold results off, so capture out_block_o whenever done_o is
// high. A new block may be started in the done_o cycle, but not while the
// previous one is in flight. After reset and after every write to cipher_key
// the round keys are expanded again: busy stays high while the schedule walks
// the memory three times, one word per step. decrypt_mode selects encryption
// (0) or decryption (1); write configuration only while busy is low and no
// result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_block_cipher_byte_key (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rc6_pkg::APB_AW-1:0]  paddr,
  input  wire logic [rc6_pkg::APB_DW-1:0]  pwdata,
  output logic      [rc6_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  // block transactions
  input  wire logic                        start,
  output logic                             busy,
  input  wire rc6_pkg::in_block_t          in_block_i,
  output logic                             done_o,
  output rc6_pkg::out_block_t              out_block_o
);

  logic                    wr_en;
  logic                    key_wr;
  logic                    mode_wr;
  rc6_pkg::key_bytes_t     cipher_key_q;
  logic                    decrypt_mode_q;
  rc6_pkg::dp_cmd_t        cmd;

  // Register writes complete in the access phase; pready is tied high
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign key_wr  = wr_en && (paddr[3] == rc6_pkg::REG_KEY);
  assign mode_wr = wr_en && (paddr[3] == rc6_pkg::REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key_q   <= '0;
      decrypt_mode_q <= 1'b0;
    end else begin
      if (key_wr) begin
        cipher_key_q <= pwdata;
      end
      if (mode_wr) begin
        decrypt_mode_q <= pwdata[0];
      end
    end
  end

  // Read back the addressed register, mode zero-extended
  assign prdata = (paddr[3] == rc6_pkg::REG_MODE) ?
                  {{(rc6_pkg::APB_DW-1){1'b0}}, decrypt_mode_q} : cipher_key_q;

  // Sequencer: key expansion after reset or key write, then block steps
  rc6_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key_wr_i   (key_wr),
    .cfg_mode_i (decrypt_mode_q),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o)
  );

  // Round key memory, schedule arithmetic and block registers
  rc6_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .key_i       (cipher_key_q),
    .in_block_i  (in_block_i),
    .out_block_o (out_block_o)
  );

endmodule

`default_nettype wire

/* rtl/rc6_checker.sv */
// ----------------------------------------------------------------------------
// rc6_checker
// Port-level checks of transaction sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rc6_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [rc6_pkg::APB_AW-1:0]  paddr,
  input wire logic [rc6_pkg::APB_DW-1:0]  pwdata,
  input wire logic [rc6_pkg::APB_DW-1:0]  prdata,
  input wire logic                        pready,
  input wire logic                        start,
  input wire logic                        busy,
  input wire rc6_pkg::in_block_t          in_block_i,
  input wire logic                        done_o,
  input wire rc6_pkg::out_block_t         out_block_o
);

  logic key_write;
  logic unused_ok;

  assign key_write = psel && penable && pwrite && pready &&
                     (paddr[3] == rc6_pkg::REG_KEY);
  assign unused_ok = ^{pwdata, prdata, in_block_i, out_block_o};

  `ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result strobe while busy")
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held longer")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted block not started")
  `ASSERT_NEXT(a_key_expand, clk_i, rst_ni, key_write, busy && !done_o, "key write without expansion")

endmodule

bind rc6_block_cipher_byte_key rc6_checker u_checker (.*);

`default_nettype wire
